>>> sv/dsmcc_pkg.sv
package dsmcc_pkg;

    localparam int MAX_MESSAGE_BYTES = 4096;
    localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 2);

    localparam logic [2:0] K_MODULE = 3'd0;
    localparam logic [2:0] K_OK     = 3'd1;
    localparam logic [2:0] K_SHORT  = 3'd2;
    localparam logic [2:0] K_BLOCK  = 3'd3;
    localparam logic [2:0] K_TRUNC  = 3'd4;
    localparam logic [2:0] K_LONG   = 3'd5;

    localparam logic [7:0]  TAG_NAME        = 8'h02;
    localparam logic [7:0]  TAG_CRC         = 8'h05;
    localparam logic [15:0] MAX_BLOCK_BYTES = 16'd4066;
    localparam int          MIN_MESSAGE_BYTES = 34;
    localparam logic [3:0]  HEAD_LAST = 4'd11;
    localparam logic [4:0]  BODY_LAST = 5'd17;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [15:0] module_number;
        logic [31:0] module_bytes;
        logic [7:0]  module_revision;
        logic [31:0] download_ident;
        logic [15:0] block_bytes;
        logic [31:0] transaction_ident;
        logic [15:0] message_ident;
        logic        crc_present;
        logic [31:0] crc_value;
        logic [11:0] name_start;
        logic [7:0]  name_bytes;
    } t_out;

    // Front-to-back entry: up to two records made by one byte.
    typedef struct packed {
        logic mod_vld;
        logic sts_vld;
        t_out mod_rec;
        t_out sts_rec;
    } t_pair;

endpackage

>>> sv/dsmcc_dii_module_list_parser_top.sv
// A record is written into the record queue when the byte that completes it is accepted.
// Throughput: one byte per cycle while the queue is not full; a byte yielding two records
// takes one entry of the two-entry record queue between parser and output.
// Input stall rises only when that queue is full.
// Reset (i_rst_n low, synchronous) returns the parser to the header and empties the queue.
module dsmcc_dii_module_list_parser_top import dsmcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    t_pair pair;
    logic  pair_vld, take;

    assign o_stall = !take;

    dsmcc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_data(i_data),
        .i_take(take), .o_pair(pair), .o_pair_vld(pair_vld)
    );

    dsmcc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pair(pair), .i_pair_vld(pair_vld),
        .o_take(take), .i_stall(i_stall), .o_valid(o_valid), .o_data(o_data)
    );

endmodule

>>> sv/dsmcc_front.sv
module dsmcc_front import dsmcc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_in   i_data,
    input  logic  i_take,
    output t_pair o_pair,
    output logic  o_pair_vld
);

    localparam logic [3:0] PH_HEAD = 4'd0, PH_ADAPT = 4'd1, PH_BODY = 4'd2,
        PH_COMPAT = 4'd3, PH_COUNT = 4'd4, PH_MODHDR = 4'd5, PH_INFO = 4'd6,
        PH_DONE = 4'd7;
    localparam logic [1:0] ST_TAG = 2'd0, ST_LEN = 2'd1, ST_BODY = 2'd2, ST_SKIP = 2'd3;

    logic [3:0]  r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_adapt, n_adapt;
    logic [15:0] r_compat, n_compat;
    logic [15:0] r_left, n_left;
    logic [7:0]  r_info, n_info;
    logic [7:0]  r_cur, n_cur;
    logic [7:0]  r_dkind, n_dkind;
    logic [7:0]  r_dlen, n_dlen;
    logic [1:0]  r_step, n_step;
    logic [31:0] r_shift, n_shift;
    logic [47:0] r_hf0, n_hf0, r_hf1, n_hf1;
    logic [55:0] r_mf0, n_mf0;
    logic        r_crcp, n_crcp;
    logic [31:0] r_crc, n_crc;
    logic [11:0] r_nst, n_nst;
    logic [7:0]  r_nlen, n_nlen;
    logic        r_blk, n_blk;
    logic        r_long, n_long;
    logic        fin;
    logic [2:0]  kind;
    t_pair       pr;
    logic [CNT_W-1:0] cnt_inc;

    function automatic t_out mk(input logic [2:0] k, input logic [47:0] h0,
                                input logic [47:0] h1);
        t_out o;
        o = '0;
        o.record_kind = k;
        o.download_ident = h1[47:16];
        o.block_bytes = h1[15:0];
        o.transaction_ident = h0[31:0];
        o.message_ident = h0[47:32];
        return o;
    endfunction

    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_pos = r_pos; n_adapt = r_adapt;
        n_compat = r_compat; n_left = r_left; n_info = r_info; n_cur = r_cur;
        n_dkind = r_dkind; n_dlen = r_dlen; n_step = r_step; n_shift = r_shift;
        n_hf0 = r_hf0; n_hf1 = r_hf1; n_mf0 = r_mf0; n_crcp = r_crcp;
        n_crc = r_crc; n_nst = r_nst; n_nlen = r_nlen; n_blk = r_blk;
        n_long = r_long; fin = 1'b0;
        cnt_inc = r_cnt;
        if (r_cnt <= CNT_W'(MAX_MESSAGE_BYTES)) cnt_inc = r_cnt + 1'b1;
        n_cnt = cnt_inc;
        if (cnt_inc > CNT_W'(MAX_MESSAGE_BYTES)) n_long = 1'b1;
        if (!n_long && !r_blk && r_phase != PH_DONE) begin
            unique case (r_phase)
                PH_HEAD: begin
                    if (r_pos >= 16'd2 && r_pos <= 16'd7)
                        n_hf0 = {r_hf0[39:0], i_data.data_byte};
                    if (r_pos == 16'd9) n_adapt = i_data.data_byte;
                    n_pos = r_pos + 1'b1;
                    if (r_pos[3:0] == HEAD_LAST) begin
                        n_pos = '0;
                        n_phase = (r_adapt != 8'd0) ? PH_ADAPT : PH_BODY;
                    end
                end
                PH_ADAPT: begin
                    n_pos = r_pos + 1'b1;
                    if (n_pos >= {8'd0, r_adapt}) begin
                        n_pos = '0; n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (r_pos <= 16'd5) n_hf1 = {r_hf1[39:0], i_data.data_byte};
                    if (r_pos == 16'd5 && (n_hf1[15:0] == 16'd0 ||
                            n_hf1[15:0] > MAX_BLOCK_BYTES)) n_blk = 1'b1;
                    if (r_pos == 16'd16 || r_pos == 16'd17)
                        n_compat = {r_compat[7:0], i_data.data_byte};
                    n_pos = r_pos + 1'b1;
                    if (r_pos[4:0] == BODY_LAST) begin
                        n_pos = '0;
                        n_phase = (n_compat != 16'd0) ? PH_COMPAT : PH_COUNT;
                    end
                end
                PH_COMPAT: begin
                    n_pos = r_pos + 1'b1;
                    if (n_pos >= r_compat) begin
                        n_pos = '0; n_phase = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    n_left = {r_left[7:0], i_data.data_byte};
                    n_pos = r_pos + 1'b1;
                    if (r_pos[0]) begin
                        n_pos = '0;
                        n_phase = (n_left != 16'd0) ? PH_MODHDR : PH_DONE;
                    end
                end
                PH_MODHDR: begin
                    if (r_pos < 16'd7) begin
                        n_mf0 = {r_mf0[47:0], i_data.data_byte};
                        n_pos = r_pos + 1'b1;
                    end else begin
                        n_info = i_data.data_byte;
                        n_crcp = 1'b0; n_crc = '0; n_nst = '0; n_nlen = '0;
                        n_cur = '0; n_step = ST_TAG; n_pos = '0;
                        if (i_data.data_byte == 8'd0) fin = 1'b1;
                        else n_phase = PH_INFO;
                    end
                end
                PH_INFO: begin
                    unique case (r_step)
                        ST_TAG: begin
                            if ({1'b0, r_cur} + 9'd2 < {1'b0, r_info}) begin
                                n_dkind = i_data.data_byte; n_step = ST_LEN;
                            end else n_step = ST_SKIP;
                        end
                        ST_LEN: begin
                            n_dlen = i_data.data_byte;
                            if ({1'b0, r_cur} + 9'd1 + {1'b0, i_data.data_byte} >
                                    {1'b0, r_info}) n_step = ST_SKIP;
                            else begin
                                if (r_dkind == TAG_NAME) begin
                                    n_nst = 12'(r_cnt + 1'b1);
                                    n_nlen = i_data.data_byte;
                                end
                                n_shift = '0; n_pos = '0;
                                n_step = (i_data.data_byte != 8'd0) ? ST_BODY : ST_TAG;
                            end
                        end
                        ST_BODY: begin
                            n_shift = {r_shift[23:0], i_data.data_byte};
                            n_pos = r_pos + 1'b1;
                            if (n_pos >= {8'd0, r_dlen}) begin
                                if (r_dkind == TAG_CRC && r_dlen == 8'd4) begin
                                    n_crcp = 1'b1; n_crc = n_shift;
                                end
                                n_pos = '0; n_step = ST_TAG;
                            end
                        end
                        default: ;
                    endcase
                    n_cur = r_cur + 1'b1;
                    if (n_cur >= r_info) fin = 1'b1;
                end
                default: ;
            endcase
            if (fin) begin
                n_left = n_left - 1'b1;
                n_phase = (n_left != 16'd0) ? PH_MODHDR : PH_DONE;
                n_pos = '0;
            end
        end
        if (n_long) kind = K_LONG;
        else if (cnt_inc < CNT_W'(MIN_MESSAGE_BYTES)) kind = K_SHORT;
        else if (n_blk) kind = K_BLOCK;
        else if (n_phase != PH_DONE) kind = K_TRUNC;
        else kind = K_OK;
        pr.mod_vld = fin;
        pr.sts_vld = i_data.last_byte;
        pr.mod_rec = mk(K_MODULE, n_hf0, n_hf1);
        pr.mod_rec.module_number = n_mf0[55:40];
        pr.mod_rec.module_bytes = n_mf0[39:8];
        pr.mod_rec.module_revision = n_mf0[7:0];
        pr.mod_rec.crc_present = n_crcp;
        pr.mod_rec.crc_value = n_crc;
        pr.mod_rec.name_start = n_nst;
        pr.mod_rec.name_bytes = n_nlen;
        pr.sts_rec = mk(kind, n_hf0, n_hf1);
    end

    // Accept only when the queue can take the produced entry.
    logic acc;
    assign acc = i_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (acc && i_data.last_byte)) begin
            r_phase <= PH_HEAD; r_cnt <= '0; r_pos <= '0; r_adapt <= '0;
            r_compat <= '0; r_left <= '0; r_info <= '0; r_cur <= '0;
            r_dkind <= '0; r_dlen <= '0; r_step <= ST_TAG; r_shift <= '0;
            r_hf0 <= '0; r_hf1 <= '0; r_mf0 <= '0; r_crcp <= 1'b0;
            r_crc <= '0; r_nst <= '0; r_nlen <= '0; r_blk <= 1'b0; r_long <= 1'b0;
        end else if (acc) begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_pos <= n_pos; r_adapt <= n_adapt;
            r_compat <= n_compat; r_left <= n_left; r_info <= n_info; r_cur <= n_cur;
            r_dkind <= n_dkind; r_dlen <= n_dlen; r_step <= n_step; r_shift <= n_shift;
            r_hf0 <= n_hf0; r_hf1 <= n_hf1; r_mf0 <= n_mf0; r_crcp <= n_crcp;
            r_crc <= n_crc; r_nst <= n_nst; r_nlen <= n_nlen; r_blk <= n_blk;
            r_long <= n_long;
        end
    end

    assign o_pair = pr;
    assign o_pair_vld = acc && (fin || i_data.last_byte);

endmodule

>>> sv/dsmcc_back.sv
module dsmcc_back import dsmcc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_pair i_pair,
    input  logic  i_pair_vld,
    output logic  o_take,
    input  logic  i_stall,
    output logic  o_valid,
    output t_out  o_data
);

    // Two-entry queue of record pairs; head pair drains one record per transfer.
    t_pair      r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;
    logic       r_half;
    logic       pop, push, head_two, done;
    t_pair      head;

    assign head = r_q[r_rd];
    assign head_two = head.mod_vld && head.sts_vld;
    assign o_valid = (r_cnt != 2'd0);
    assign o_data = (head.mod_vld && !r_half) ? head.mod_rec : head.sts_rec;
    assign pop = o_valid && !i_stall;
    assign done = pop && (!head_two || r_half);
    assign o_take = (r_cnt != 2'd2);
    assign push = i_pair_vld;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_pair;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_rd <= 1'b0; r_wr <= 1'b0; r_half <= 1'b0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (done) begin
                r_rd <= !r_rd; r_half <= 1'b0;
            end else if (pop) r_half <= 1'b1;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, done};
        end
    end

endmodule

>>> bench/tb_dsmcc_dii_module_list_parser_top.sv
module tb_dsmcc_dii_module_list_parser_top;
    import dsmcc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 1650;

    typedef enum int {PH_HEAD, PH_ADAPT, PH_BODY, PH_COMPAT, PH_COUNT,
                      PH_MODHDR, PH_INFO, PH_DONE} t_phase;
    typedef enum int {DS_TAG, DS_LEN, DS_BODY, DS_SKIP} t_dstep;

    class record_board;
        t_out   pending[$];
        int     errors;
        t_phase phase;
        t_dstep dstep;
        int unsigned nbytes, adapt, compat, mods, info, cur, dkind, dlen, ppos;
        logic [31:0] shift;
        logic [63:0] hf0, hf1, mf0, mf1;
        logic [2:0]  err;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_HEAD; dstep = DS_TAG;
            nbytes = 0; adapt = 0; compat = 0; mods = 0; info = 0;
            cur = 0; dkind = 0; dlen = 0; ppos = 0; shift = '0;
            hf0 = '0; hf1 = '0; mf0 = '0; mf1 = '0; err = '0;
        endfunction

        function t_out make(logic [2:0] kind, bit with_mod);
            t_out r;
            logic [63:0] m0, m1;
            m0 = with_mod ? mf0 : 64'd0;
            m1 = with_mod ? mf1 : 64'd0;
            r.record_kind       = kind;
            r.module_number     = m0[55:40];
            r.module_bytes      = m0[39:8];
            r.module_revision   = m0[7:0];
            r.download_ident    = hf1[47:16];
            r.block_bytes       = hf1[15:0];
            r.transaction_ident = hf0[31:0];
            r.message_ident     = hf0[47:32];
            r.crc_present       = m1[32];
            r.crc_value         = m1[31:0];
            r.name_start        = m1[44:33];
            r.name_bytes        = m1[52:45];
            return r;
        endfunction

        function void close_module();
            pending.push_back(make(K_MODULE, 1));
            mods = (mods - 1) & 16'hFFFF;
            phase = (mods != 0) ? PH_MODHDR : PH_DONE;
            ppos = 0;
        endfunction

        function void consume(logic [7:0] b, int unsigned pos);
            case (phase)
                PH_HEAD: begin
                    if (ppos >= 2 && ppos <= 7) hf0 = ((hf0 << 8) | b) & 64'hFFFF_FFFF_FFFF;
                    if (ppos == 9) adapt = b;
                    ppos++;
                    if (ppos == 12) begin
                        ppos = 0;
                        phase = (adapt != 0) ? PH_ADAPT : PH_BODY;
                    end
                end
                PH_ADAPT: begin
                    ppos++;
                    if (ppos >= adapt) begin
                        ppos = 0; phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (ppos <= 5) hf1 = ((hf1 << 8) | b) & 64'hFFFF_FFFF_FFFF;
                    if (ppos == 5 && (hf1[15:0] == 0 || hf1[15:0] > MAX_BLOCK_BYTES))
                        err = K_BLOCK;
                    if (ppos == 16 || ppos == 17) compat = ((compat << 8) | b) & 16'hFFFF;
                    ppos++;
                    if (ppos == 18) begin
                        ppos = 0;
                        phase = (compat != 0) ? PH_COMPAT : PH_COUNT;
                    end
                end
                PH_COMPAT: begin
                    ppos++;
                    if (ppos >= compat) begin
                        ppos = 0; phase = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    mods = ((mods << 8) | b) & 16'hFFFF;
                    ppos++;
                    if (ppos == 2) begin
                        ppos = 0;
                        phase = (mods != 0) ? PH_MODHDR : PH_DONE;
                    end
                end
                PH_MODHDR: begin
                    if (ppos < 7) begin
                        mf0 = ((mf0 << 8) | b) & 64'hFF_FFFF_FFFF_FFFF;
                        ppos++;
                    end else begin
                        info = b; mf1 = '0; cur = 0; dstep = DS_TAG; ppos = 0;
                        if (info == 0) close_module();
                        else phase = PH_INFO;
                    end
                end
                PH_INFO: begin
                    case (dstep)
                        DS_TAG: begin
                            if (cur + 2 < info) begin
                                dkind = b; dstep = DS_LEN;
                            end else begin
                                dstep = DS_SKIP;
                            end
                        end
                        DS_LEN: begin
                            dlen = b;
                            if (cur + 1 + dlen > info) begin
                                dstep = DS_SKIP;
                            end else begin
                                if (dkind == TAG_NAME) begin
                                    mf1[44:33] = 12'(pos + 1);
                                    mf1[52:45] = dlen[7:0];
                                end
                                shift = '0; ppos = 0;
                                dstep = (dlen != 0) ? DS_BODY : DS_TAG;
                            end
                        end
                        DS_BODY: begin
                            shift = (shift << 8) | b;
                            ppos++;
                            if (ppos >= dlen) begin
                                if (dkind == TAG_CRC && dlen == 4) mf1[32:0] = {1'b1, shift};
                                ppos = 0; dstep = DS_TAG;
                            end
                        end
                        default: ;
                    endcase
                    cur++;
                    if (cur >= info) close_module();
                end
                default: ;
            endcase
        endfunction

        // note an accepted input byte and queue the records it yields
        function void note(t_in x);
            int unsigned pos;
            logic [2:0] kind;
            pos = nbytes;
            if (nbytes <= MAX_MESSAGE_BYTES) nbytes++;
            if (nbytes > MAX_MESSAGE_BYTES) err = K_LONG;
            if (err == 0 && phase != PH_DONE) consume(x.data_byte, pos);
            if (x.last_byte) begin
                if (err == K_LONG) kind = K_LONG;
                else if (nbytes < MIN_MESSAGE_BYTES) kind = K_SHORT;
                else if (err == K_BLOCK) kind = K_BLOCK;
                else if (phase != PH_DONE) kind = K_TRUNC;
                else kind = K_OK;
                pending.push_back(make(kind, 0));
                clear();
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
            errors++;
        endtask

        task cmp(string what, logic [63:0] got, logic [63:0] want);
            if (got !== want) report(what, got, want);
        endtask

        task check(t_out got);
            t_out w;
            if (pending.size() == 0) begin
                report("unexpected record", got.record_kind, 0);
            end else begin
                w = pending.pop_front();
                cmp("record_kind", got.record_kind, w.record_kind);
                cmp("module_number", got.module_number, w.module_number);
                cmp("module_bytes", got.module_bytes, w.module_bytes);
                cmp("module_revision", got.module_revision, w.module_revision);
                cmp("download_ident", got.download_ident, w.download_ident);
                cmp("block_bytes", got.block_bytes, w.block_bytes);
                cmp("transaction_ident", got.transaction_ident, w.transaction_ident);
                cmp("message_ident", got.message_ident, w.message_ident);
                cmp("crc_present", got.crc_present, w.crc_present);
                cmp("crc_value", got.crc_value, w.crc_value);
                cmp("name_start", got.name_start, w.name_start);
                cmp("name_bytes", got.name_bytes, w.name_bytes);
            end
        endtask
    endclass

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    t_in  i_data;
    t_out o_data;

    record_board board = new();
    logic [7:0] msg_q[$];
    bit calm = 0;
    bit drained = 0;
    int sent = 0;
    int cycles = 0;

    dsmcc_dii_module_list_parser_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check(o_data);
    end

    // receiver stall bursts
    initial begin
        i_stall <= 1'b0;
        forever begin
            if (calm || $urandom_range(0, 3) != 0) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
        end
    end

    task send_byte(logic [7:0] b, bit last);
        t_in x;
        x.data_byte = b;
        x.last_byte = last;
        if (!calm && $urandom_range(0, 15) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= x;
        do @(posedge i_clk); while (o_stall);
        board.note(x);
        sent++;
    endtask

    task send_msg();
        foreach (msg_q[k]) send_byte(msg_q[k], k == msg_q.size() - 1);
    endtask

    task push_rand(int n);
        repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // build one message; mode 0 well formed, 1 cut short, 2 noise, 3 bad block, 4 over length
    task build(int mode, int blk);
        logic [7:0] info_q[$];
        int a, c, n, l;
        msg_q.delete();
        if (mode == 2) begin
            push_rand($urandom_range(1, 40));
            return;
        end
        a = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
        push_rand(9);
        msg_q.push_back(8'(a));
        push_rand(2 + a);
        push_rand(4);
        if (blk < 0) begin
            if (mode == 3) blk = $urandom_range(0, 1) ? 0 : $urandom_range(4067, 65535);
            else blk = $urandom_range(1, 4066);
        end
        msg_q.push_back(blk[15:8]);
        msg_q.push_back(blk[7:0]);
        push_rand(10);
        c = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        msg_q.push_back(8'd0);
        msg_q.push_back(8'(c));
        push_rand(c);
        n = $urandom_range(0, 3);
        msg_q.push_back(8'd0);
        msg_q.push_back(8'(n));
        repeat (n) begin
            push_rand(7);
            info_q.delete();
            repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(0, 4))
                    0: begin
                        l = $urandom_range(0, 5);
                        info_q.push_back(TAG_NAME); info_q.push_back(8'(l));
                        repeat (l) info_q.push_back(8'($urandom_range(0, 255)));
                    end
                    1, 2: begin
                        l = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : 4;
                        info_q.push_back(TAG_CRC); info_q.push_back(8'(l));
                        repeat (l) info_q.push_back(8'($urandom_range(0, 255)));
                    end
                    3: begin
                        l = $urandom_range(0, 3);
                        info_q.push_back(8'($urandom_range(0, 255)));
                        info_q.push_back(8'(l));
                        repeat (l) info_q.push_back(8'($urandom_range(0, 255)));
                    end
                    default: begin
                        // length overruns the info area
                        info_q.push_back($urandom_range(0, 1) ? TAG_NAME : TAG_CRC);
                        info_q.push_back(8'($urandom_range(60, 255)));
                    end
                endcase
            end
            repeat ($urandom_range(0, 2)) info_q.push_back(8'($urandom_range(0, 255)));
            msg_q.push_back(8'(info_q.size()));
            foreach (info_q[k]) msg_q.push_back(info_q[k]);
        end
        if (mode == 0) push_rand($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        if (mode == 1) begin
            l = $urandom_range(1, msg_q.size() - 1);
            while (msg_q.size() > l) void'(msg_q.pop_back());
        end
        if (mode == 4) while (msg_q.size() < MAX_MESSAGE_BYTES + 3)
            msg_q.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int r;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: lone byte, two-byte message, block size extremes
        msg_q.delete(); msg_q.push_back(8'hFF); send_msg();
        msg_q.delete(); msg_q.push_back(8'h00); msg_q.push_back(8'hFF); send_msg();
        build(0, 1);    send_msg();
        build(0, 4066); send_msg();
        build(3, 0);    send_msg();
        build(3, 4067); send_msg();
        build(3, 65535); send_msg();

        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 19);
            if (r < 13) build(0, -1);
            else if (r < 16) build(1, -1);
            else if (r < 18) build(2, -1);
            else build(3, -1);
            send_msg();
            if (!drained && sent > RANDOM_ITEMS / 2) begin
                // hold off until the parser has drained
                drained = 1;
                i_valid <= 1'b0;
                while (board.pending.size() != 0) @(posedge i_clk);
            end
        end
        calm = 1;
        repeat (3) begin
            build(0, -1); send_msg();
        end
        i_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

>>> files.f
sv/dsmcc_pkg.sv
sv/dsmcc_front.sv
sv/dsmcc_back.sv
sv/dsmcc_dii_module_list_parser_top.sv
bench/tb_dsmcc_dii_module_list_parser_top.sv
